FILE: rtl/latest_frame_slot_manager_top_macros.svh
// Assertion helpers shared by the slot manager modules.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef LATEST_FRAME_SLOT_MANAGER_TOP_MACROS_SVH
`define LATEST_FRAME_SLOT_MANAGER_TOP_MACROS_SVH

// Same-cycle implication.
`define LFSM_ASSERT_IMP(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("slot manager check failed");

// Next-cycle implication.
`define LFSM_ASSERT_NXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("slot manager check failed");

`endif

FILE: rtl/lfsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfsm_pkg;

    localparam int SLOT_COUNT = 3;
    localparam int SLOT_SEL_W = $clog2(SLOT_COUNT);

    localparam int CMD_W      = 3;
    localparam int SLOT_IDX_W = 4;
    localparam int IDX_CMP_W  = SLOT_IDX_W + 1;
    localparam int KIND_W     = 2;
    localparam int DIM_W      = 16;
    localparam int CNT_W      = 32;

    localparam logic [CMD_W-1:0] CMD_SET_DIMS      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ACQUIRE_WRITE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUBLISH_SLOT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PUBLISH_FRAME = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ACQUIRE_READ  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RELEASE_READ  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RESET         = 3'd6;
    localparam logic [CMD_W-1:0] CMD_NOP           = 3'd7;

    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CPU_RGBA = 2'd1;

    typedef struct packed {
        logic [CMD_W-1:0]      command;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [KIND_W-1:0]     frame_kind;
        logic [DIM_W-1:0]      frame_width;
        logic [DIM_W-1:0]      frame_height;
    } cmd_t;

    typedef struct packed {
        logic                  success;
        logic [SLOT_IDX_W-1:0] slot;
        logic [KIND_W-1:0]     kind;
        logic [DIM_W-1:0]      width;
        logic [DIM_W-1:0]      height;
        logic [CNT_W-1:0]      published_total;
        logic [CNT_W-1:0]      dropped_total;
    } res_t;

    typedef struct packed {
        logic                  found;
        logic [SLOT_SEL_W-1:0] slot;
    } pick_t;

endpackage

`default_nettype wire

FILE: rtl/lfsm_pick.sv
`timescale 1ns / 1ps
`default_nettype none

// Lowest slot whose blocked bit is clear.
module lfsm_pick (
    input  wire logic [lfsm_pkg::SLOT_COUNT-1:0] blocked,
    output lfsm_pkg::pick_t                      pick
);

    always_comb
    begin
        pick = '0;
        for (int i = lfsm_pkg::SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!blocked[i])
            begin
                pick.found = 1'b1;
                pick.slot  = lfsm_pkg::SLOT_SEL_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lfsm_core.sv
`timescale 1ns / 1ps
`default_nettype none

`include "latest_frame_slot_manager_top_macros.svh"

// Slot ownership state and the per-command update.
module lfsm_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  lfsm_pkg::cmd_t      in_cmd,
    output lfsm_pkg::res_t      res
);

    localparam int N = lfsm_pkg::SLOT_COUNT;
    localparam int SW = lfsm_pkg::SLOT_SEL_W;

    logic [N-1:0]                    written_reg, written_next;
    logic [lfsm_pkg::KIND_W-1:0]     kind_reg   [N];
    logic [lfsm_pkg::KIND_W-1:0]     kind_next  [N];
    logic [lfsm_pkg::DIM_W-1:0]      width_reg  [N];
    logic [lfsm_pkg::DIM_W-1:0]      width_next [N];
    logic [lfsm_pkg::DIM_W-1:0]      height_reg [N];
    logic [lfsm_pkg::DIM_W-1:0]      height_next[N];
    logic                            rd_hold_reg, rd_hold_next;
    logic [SW-1:0]                   rd_slot_reg, rd_slot_next;
    logic                            has_pub_reg, has_pub_next;
    logic [SW-1:0]                   pub_slot_reg, pub_slot_next;
    logic [lfsm_pkg::DIM_W-1:0]      cur_w_reg, cur_w_next;
    logic [lfsm_pkg::DIM_W-1:0]      cur_h_reg, cur_h_next;
    logic [lfsm_pkg::CNT_W-1:0]      pub_cnt_reg, pub_cnt_next;
    logic [lfsm_pkg::CNT_W-1:0]      drop_cnt_reg, drop_cnt_next;

    logic [N-1:0]                    blocked;
    lfsm_pkg::pick_t                 free_pick;
    logic                            pub_req;
    logic [SW-1:0]                   pub_sel;
    logic                            drop_inc;
    logic [SW-1:0]                   idx_sel;
    logic                            idx_ok;
    logic                            acq_hit;
    logic                            rd_hit;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            blocked[i] = (rd_hold_reg && rd_slot_reg == SW'(i))
                || (has_pub_reg && pub_slot_reg == SW'(i))
                || written_reg[i];
        end
    end

    lfsm_pick u_pick (
        .blocked (blocked),
        .pick    (free_pick)
    );

    assign idx_sel = in_cmd.slot_index[SW-1:0];
    assign idx_ok  = lfsm_pkg::IDX_CMP_W'(in_cmd.slot_index)
        < lfsm_pkg::IDX_CMP_W'(N);

    always_comb
    begin
        written_next  = written_reg;
        kind_next     = kind_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        rd_hold_next  = rd_hold_reg;
        rd_slot_next  = rd_slot_reg;
        has_pub_next  = has_pub_reg;
        pub_slot_next = pub_slot_reg;
        cur_w_next    = cur_w_reg;
        cur_h_next    = cur_h_reg;
        pub_cnt_next  = pub_cnt_reg;
        drop_cnt_next = drop_cnt_reg;
        pub_req       = 1'b0;
        pub_sel       = '0;
        drop_inc      = 1'b0;
        res           = '0;

        if (in_valid)
        begin
            unique case (in_cmd.command)
                lfsm_pkg::CMD_SET_DIMS:
                begin
                    if (in_cmd.frame_width != cur_w_reg || in_cmd.frame_height != cur_h_reg)
                    begin
                        cur_w_next   = in_cmd.frame_width;
                        cur_h_next   = in_cmd.frame_height;
                        has_pub_next = 1'b0;
                    end
                end
                lfsm_pkg::CMD_ACQUIRE_WRITE:
                begin
                    if (free_pick.found)
                    begin
                        written_next[free_pick.slot] = 1'b1;
                        res.success = 1'b1;
                        res.slot    = lfsm_pkg::SLOT_IDX_W'(free_pick.slot);
                    end
                    else
                    begin
                        drop_inc = 1'b1;
                    end
                end
                lfsm_pkg::CMD_PUBLISH_SLOT:
                begin
                    if (idx_ok)
                    begin
                        written_next[idx_sel] = 1'b0;
                        kind_next[idx_sel]    = lfsm_pkg::KIND_CPU_RGBA;
                        width_next[idx_sel]   = cur_w_reg;
                        height_next[idx_sel]  = cur_h_reg;
                        pub_req     = 1'b1;
                        pub_sel     = idx_sel;
                        res.success = 1'b1;
                        res.slot    = in_cmd.slot_index;
                    end
                end
                lfsm_pkg::CMD_PUBLISH_FRAME:
                begin
                    if (free_pick.found)
                    begin
                        kind_next[free_pick.slot]   = in_cmd.frame_kind;
                        width_next[free_pick.slot]  = in_cmd.frame_width;
                        height_next[free_pick.slot] = in_cmd.frame_height;
                        cur_w_next  = in_cmd.frame_width;
                        cur_h_next  = in_cmd.frame_height;
                        pub_req     = 1'b1;
                        pub_sel     = free_pick.slot;
                        res.success = 1'b1;
                        res.slot    = lfsm_pkg::SLOT_IDX_W'(free_pick.slot);
                    end
                    else
                    begin
                        drop_inc = 1'b1;
                    end
                end
                lfsm_pkg::CMD_ACQUIRE_READ:
                begin
                    if (has_pub_reg && kind_reg[pub_slot_reg] != lfsm_pkg::KIND_NONE)
                    begin
                        rd_hold_next = 1'b1;
                        rd_slot_next = pub_slot_reg;
                        has_pub_next = 1'b0;
                        res.success  = 1'b1;
                        res.slot     = lfsm_pkg::SLOT_IDX_W'(pub_slot_reg);
                        res.kind     = kind_reg[pub_slot_reg];
                        res.width    = width_reg[pub_slot_reg];
                        res.height   = height_reg[pub_slot_reg];
                    end
                end
                lfsm_pkg::CMD_RELEASE_READ:
                begin
                    rd_hold_next = 1'b0;
                end
                lfsm_pkg::CMD_RESET:
                begin
                    has_pub_next = 1'b0;
                    for (int i = 0; i < N; i++)
                    begin
                        if (!((rd_hold_reg && rd_slot_reg == SW'(i)) || written_reg[i]))
                        begin
                            kind_next[i]   = lfsm_pkg::KIND_NONE;
                            width_next[i]  = '0;
                            height_next[i] = '0;
                        end
                    end
                end
                lfsm_pkg::CMD_NOP:
                begin
                end
            endcase

            // publish: count it, and drop a different unread frame it replaces
            if (pub_req)
            begin
                if (has_pub_reg && pub_slot_reg != pub_sel)
                begin
                    drop_inc = 1'b1;
                end
                has_pub_next  = 1'b1;
                pub_slot_next = pub_sel;
                pub_cnt_next  = pub_cnt_reg + 1'b1;
            end

            if (drop_inc)
            begin
                drop_cnt_next = drop_cnt_reg + 1'b1;
            end
        end

        res.published_total = pub_cnt_next;
        res.dropped_total   = drop_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg  <= '0;
            rd_hold_reg  <= 1'b0;
            rd_slot_reg  <= '0;
            has_pub_reg  <= 1'b0;
            pub_slot_reg <= '0;
            cur_w_reg    <= '0;
            cur_h_reg    <= '0;
            pub_cnt_reg  <= '0;
            drop_cnt_reg <= '0;
            for (int i = 0; i < N; i++)
            begin
                kind_reg[i]   <= lfsm_pkg::KIND_NONE;
                width_reg[i]  <= '0;
                height_reg[i] <= '0;
            end
        end
        else
        begin
            written_reg  <= written_next;
            rd_hold_reg  <= rd_hold_next;
            rd_slot_reg  <= rd_slot_next;
            has_pub_reg  <= has_pub_next;
            pub_slot_reg <= pub_slot_next;
            cur_w_reg    <= cur_w_next;
            cur_h_reg    <= cur_h_next;
            pub_cnt_reg  <= pub_cnt_next;
            drop_cnt_reg <= drop_cnt_next;
            kind_reg     <= kind_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
        end
    end

    assign acq_hit = in_valid && in_cmd.command == lfsm_pkg::CMD_ACQUIRE_WRITE
        && free_pick.found;
    assign rd_hit  = in_valid && in_cmd.command == lfsm_pkg::CMD_ACQUIRE_READ
        && res.success;

    // a granted write slot is marked as being written
    `LFSM_ASSERT_NXT(a_acq_marks_slot, acq_hit, written_reg[$past(free_pick.slot)])
    // the reader is never handed an empty slot
    `LFSM_ASSERT_IMP(a_read_not_empty, rd_hit, res.kind != lfsm_pkg::KIND_NONE)
    // the drop count moves by at most one per command
    `LFSM_ASSERT_NXT(a_drop_step, 1'b1, (drop_cnt_reg - $past(drop_cnt_reg)) <= 32'd1)

endmodule

`default_nettype wire

FILE: rtl/latest_frame_slot_manager_top.sv
`timescale 1ns / 1ps
`default_nettype none

`include "latest_frame_slot_manager_top_macros.svh"

// Latest-frame slot manager: a triple-buffer mailbox that hands frame slots
// between one producer and one consumer. A command word is taken on every
// clock edge where start is high; busy is always low, so one command per cycle
// is sustained. Each command yields exactly one result word: the command is
// held in the input register and then passes through the slot update logic into
// the result register, which is loaded together with done, so the word is valid
// on the cycle done is high and stays until the next result. The
// receiver cannot stall: capture the result ports on the cycle done is high,
// since the next command overwrites them. published_total and dropped_total
// report the counters after the command and wrap at 2^32.
// Commands see the state left by every earlier command, with no gaps needed.
module latest_frame_slot_manager_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic [2:0]  command,
    input  wire logic [3:0]  slot_index,
    input  wire logic [1:0]  frame_kind,
    input  wire logic [15:0] frame_width,
    input  wire logic [15:0] frame_height,
    output      logic        done,
    output      logic        success,
    output      logic [3:0]  result_slot,
    output      logic [1:0]  read_kind,
    output      logic [15:0] read_width,
    output      logic [15:0] read_height,
    output      logic [31:0] published_total,
    output      logic [31:0] dropped_total
);

    logic            in_valid_reg;
    lfsm_pkg::cmd_t  cmd_reg;
    lfsm_pkg::res_t  res_next;
    logic            done_reg;
    lfsm_pkg::res_t  res_reg;

    // never stall the producer
    assign busy = 1'b0;

    // register the accepted command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg.command      <= command;
            cmd_reg.slot_index   <= slot_index;
            cmd_reg.frame_kind   <= frame_kind;
            cmd_reg.frame_width  <= frame_width;
            cmd_reg.frame_height <= frame_height;
        end
    end

    lfsm_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .in_cmd   (cmd_reg),
        .res      (res_next)
    );

    // register the result; done pulses for one cycle per command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign done            = done_reg;
    assign success         = res_reg.success;
    assign result_slot     = res_reg.slot;
    assign read_kind       = res_reg.kind;
    assign read_width      = res_reg.width;
    assign read_height     = res_reg.height;
    assign published_total = res_reg.published_total;
    assign dropped_total   = res_reg.dropped_total;

    // every accepted command yields exactly one result
    `LFSM_ASSERT_NXT(a_cmd_gives_done, start && !busy, in_valid_reg)
    `LFSM_ASSERT_NXT(a_done_follows, in_valid_reg, done_reg)
    `LFSM_ASSERT_NXT(a_no_spurious_done, !in_valid_reg, !done_reg)

endmodule

`default_nettype wire
